[design/assert_macros.svh]
// assertion helpers used by wav_header_parser_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[design/whp_pkg.sv]
package whp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_RIFFSIZE  = 4'd1,
    PH_WAVE      = 4'd2,
    PH_SCANFMT   = 4'd3,
    PH_FMTSIZE   = 4'd4,
    PH_FORMAT    = 4'd5,
    PH_CHANNELS  = 4'd6,
    PH_RATE      = 4'd7,
    PH_SKIPSIX   = 4'd8,
    PH_BITS      = 4'd9,
    PH_EXTRA     = 4'd10,
    PH_CHUNKID   = 4'd11,
    PH_CHUNKSIZE = 4'd12,
    PH_SKIPCHUNK = 4'd13,
    PH_DATASIZE  = 4'd14,
    PH_DONE      = 4'd15
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNC     = 4'd1,
    ST_BAD_RIFF  = 4'd2,
    ST_BAD_WAVE  = 4'd3,
    ST_FMT_SIZE  = 4'd4,
    ST_NOT_PCM   = 4'd5,
    ST_CHANNELS  = 4'd6,
    ST_ZERO_RATE = 4'd7,
    ST_BIT_DEPTH = 4'd8
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_BASE = 32'd16;
  localparam logic [31:0] FMT_SIZE_EXT  = 32'd18;
  localparam logic [31:0] FMT_SIZE_WIDE = 32'd40;
  localparam logic [4:0]  EXTRA_EXT     = 5'(18 - 16);
  localparam logic [4:0]  EXTRA_WIDE    = 5'(40 - 16);
  localparam logic [31:0] SKIP_SIX      = 32'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] data_length;
  } out_item_t;

endpackage

[design/wav_header_parser_unit.sv]
// the final header byte passes the input register, then its result is registered
// throughput: one byte per cycle, limited only by the result register being stalled
// one result per file: success, first error, or truncation on the last byte
// reset: synchronous active-low rst_n; parser expects the riff tag, both stages empty
`include "assert_macros.svh"

module wav_header_parser_unit
  import whp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  phase_t      ph_r, ph_nxt;
  logic [1:0]  biw_r, biw_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [4:0]  extra_r, extra_nxt;
  logic [1:0]  hch_r, hch_nxt;
  logic [4:0]  hbits_r, hbits_nxt;
  logic [31:0] hrate_r, hrate_nxt;

  logic        advance;
  logic        step;
  phase_t      eff_ph;
  logic [1:0]  eff_biw;
  logic [31:0] eff_ws;
  logic [31:0] eff_skip;
  logic [4:0]  eff_extra;
  logic [31:0] ws_new;
  logic [15:0] v;
  logic        done4;
  logic        done2;
  logic [31:0] skip_dec;
  logic [4:0]  extra_dec;
  logic        res_vld;
  status_t     res_code;
  out_item_t   res_item;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // restart view of the state when a file begins
  assign eff_ph    = in_item_r.first_byte ? PH_RIFF : ph_r;
  assign eff_biw   = in_item_r.first_byte ? 2'd0 : biw_r;
  assign eff_ws    = in_item_r.first_byte ? 32'd0 : ws_r;
  assign eff_skip  = in_item_r.first_byte ? 32'd0 : skip_r;
  assign eff_extra = in_item_r.first_byte ? 5'd0 : extra_r;

  assign ws_new    = {in_item_r.data_byte, eff_ws[31:8]};
  assign v         = ws_new[31:16];
  assign done4     = (eff_biw == 2'd3);
  assign done2     = (eff_biw != 2'd0);
  assign skip_dec  = eff_skip - 32'd1;
  assign extra_dec = eff_extra - 5'd1;

  // result decision
  always_comb begin
    res_vld  = 1'b0;
    res_code = ST_OK;
    case (eff_ph)
      PH_RIFF: begin
        if (done4 && ws_new != TAG_RIFF) begin
          res_vld  = 1'b1;
          res_code = ST_BAD_RIFF;
        end
      end
      PH_WAVE: begin
        if (done4 && ws_new != TAG_WAVE) begin
          res_vld  = 1'b1;
          res_code = ST_BAD_WAVE;
        end
      end
      PH_FMTSIZE: begin
        if (done4 && ws_new != FMT_SIZE_BASE && ws_new != FMT_SIZE_EXT &&
            ws_new != FMT_SIZE_WIDE) begin
          res_vld  = 1'b1;
          res_code = ST_FMT_SIZE;
        end
      end
      PH_FORMAT: begin
        if (done2 && v != 16'd1) begin
          res_vld  = 1'b1;
          res_code = ST_NOT_PCM;
        end
      end
      PH_CHANNELS: begin
        if (done2 && v != 16'd1 && v != 16'd2) begin
          res_vld  = 1'b1;
          res_code = ST_CHANNELS;
        end
      end
      PH_RATE: begin
        if (done4 && ws_new == 32'd0) begin
          res_vld  = 1'b1;
          res_code = ST_ZERO_RATE;
        end
      end
      PH_BITS: begin
        if (done2 && v != 16'd8 && v != 16'd16) begin
          res_vld  = 1'b1;
          res_code = ST_BIT_DEPTH;
        end
      end
      PH_DATASIZE: begin
        if (done4) begin
          res_vld  = 1'b1;
          res_code = ST_OK;
        end
      end
      default: begin
      end
    endcase
    if (eff_ph != PH_DONE && !res_vld && in_item_r.last_byte) begin
      res_vld  = 1'b1;
      res_code = ST_TRUNC;
    end
    res_item.status = res_code;
    if (res_code == ST_OK) begin
      res_item.channel_count = hch_r;
      res_item.sample_bits   = hbits_r;
      res_item.rate_hz       = hrate_r;
      res_item.data_length   = ws_new;
    end else begin
      res_item.channel_count = 2'd0;
      res_item.sample_bits   = 5'd0;
      res_item.rate_hz       = 32'd0;
      res_item.data_length   = 32'd0;
    end
  end

  // next state
  always_comb begin
    ph_nxt    = eff_ph;
    biw_nxt   = eff_biw;
    ws_nxt    = ws_new;
    skip_nxt  = eff_skip;
    extra_nxt = eff_extra;
    hch_nxt   = in_item_r.first_byte ? 2'd0 : hch_r;
    hbits_nxt = in_item_r.first_byte ? 5'd0 : hbits_r;
    hrate_nxt = in_item_r.first_byte ? 32'd0 : hrate_r;
    case (eff_ph)
      PH_RIFF, PH_RIFFSIZE, PH_WAVE, PH_SCANFMT, PH_FMTSIZE, PH_RATE,
      PH_CHUNKID, PH_CHUNKSIZE, PH_DATASIZE: begin
        biw_nxt = done4 ? 2'd0 : 2'(eff_biw + 2'd1);
      end
      PH_FORMAT, PH_CHANNELS, PH_BITS: begin
        biw_nxt = done2 ? 2'd0 : 2'(eff_biw + 2'd1);
      end
      default: begin
      end
    endcase
    case (eff_ph)
      PH_RIFF: begin
        if (done4) ph_nxt = PH_RIFFSIZE;
      end
      PH_RIFFSIZE: begin
        if (done4) ph_nxt = PH_WAVE;
      end
      PH_WAVE: begin
        if (done4) ph_nxt = PH_SCANFMT;
      end
      PH_SCANFMT: begin
        if (done4 && ws_new == TAG_FMT) ph_nxt = PH_FMTSIZE;
      end
      PH_FMTSIZE: begin
        if (done4) begin
          ph_nxt = PH_FORMAT;
          if (ws_new == FMT_SIZE_EXT) begin
            extra_nxt = EXTRA_EXT;
          end else if (ws_new == FMT_SIZE_WIDE) begin
            extra_nxt = EXTRA_WIDE;
          end else begin
            extra_nxt = 5'd0;
          end
        end
      end
      PH_FORMAT: begin
        if (done2) ph_nxt = PH_CHANNELS;
      end
      PH_CHANNELS: begin
        if (done2) begin
          hch_nxt = v[1:0];
          ph_nxt  = PH_RATE;
        end
      end
      PH_RATE: begin
        if (done4) begin
          hrate_nxt = ws_new;
          skip_nxt  = SKIP_SIX;
          ph_nxt    = PH_SKIPSIX;
        end
      end
      PH_SKIPSIX: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) ph_nxt = PH_BITS;
      end
      PH_BITS: begin
        if (done2) begin
          hbits_nxt = v[4:0];
          ph_nxt    = (eff_extra == 5'd0) ? PH_CHUNKID : PH_EXTRA;
        end
      end
      PH_EXTRA: begin
        extra_nxt = extra_dec;
        if (extra_dec == 5'd0) ph_nxt = PH_CHUNKID;
      end
      PH_CHUNKID: begin
        if (done4) ph_nxt = (ws_new == TAG_DATA) ? PH_DATASIZE : PH_CHUNKSIZE;
      end
      PH_CHUNKSIZE: begin
        if (done4) begin
          skip_nxt = ws_new;
          ph_nxt   = (ws_new == 32'd0) ? PH_CHUNKID : PH_SKIPCHUNK;
        end
      end
      PH_SKIPCHUNK: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) ph_nxt = PH_CHUNKID;
      end
      default: begin
      end
    endcase
    if (eff_ph == PH_DONE) begin
      ws_nxt = eff_ws;
    end
    if (res_vld) ph_nxt = PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_RIFF;
      biw_r   <= 2'd0;
      ws_r    <= 32'd0;
      skip_r  <= 32'd0;
      extra_r <= 5'd0;
      hch_r   <= 2'd0;
      hbits_r <= 5'd0;
      hrate_r <= 32'd0;
    end else if (step) begin
      ph_r    <= ph_nxt;
      biw_r   <= biw_nxt;
      ws_r    <= ws_nxt;
      skip_r  <= skip_nxt;
      extra_r <= extra_nxt;
      hch_r   <= hch_nxt;
      hbits_r <= hbits_nxt;
      hrate_r <= hrate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res_vld;
    end
    if (step && res_vld) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_PROP(a_result_ends_file, clk, rst_n, $rose(out_valid_r) |-> ph_r == PH_DONE)
  `ASSERT_PROP(a_ok_fields, clk, rst_n,
    (out_valid_r && out_item_r.status == ST_OK) |->
      (out_item_r.channel_count != 2'd0 &&
       (out_item_r.sample_bits == 5'd8 || out_item_r.sample_bits == 5'd16) &&
       out_item_r.rate_hz != 32'd0))
  `ASSERT_PROP(a_err_zero, clk, rst_n,
    (out_valid_r && out_item_r.status != ST_OK) |->
      (out_item_r.channel_count == 2'd0 && out_item_r.sample_bits == 5'd0 &&
       out_item_r.rate_hz == 32'd0 && out_item_r.data_length == 32'd0))
  `ASSERT_NEVER(a_stall_empty, clk, rst_n, in_stall && !in_vld_r)

endmodule
